// ===== rtl/nfba_pkg.sv =====
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared types and constants of the next-fit block map allocator.
// ----------------------------------------------------------------------------
package nfba_pkg;

  // Fixed field widths of the stream payloads
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int BYTES_W = 15;
  localparam int REG_W   = 11;

  // Owner id stamped on the reserved header blocks
  localparam logic [7:0]       HEADER_ID    = 8'd5;
  // Region size register after reset
  localparam logic [REG_W-1:0] REGION_RESET = 11'd1024;

  // Request kinds carried on in_tuser
  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_INIT  = 2'd2
  } req_t;

  // Result status carried on out_tuser
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOROOM  = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  // One result item handed from the engine to the output register
  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] block_index;
    logic [CNT_W-1:0] block_count;
    logic [CNT_W-1:0] free_blocks;
  } res_t;

  // Engine sequencer states
  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_IPREP,
    S_IDIV,
    S_APREP,
    S_ACHK,
    S_SCAN,
    S_LEFT,
    S_RIGHT,
    S_PICK,
    S_FILL,
    S_FCHK,
    S_FWALK,
    S_FINISH
  } eng_state_t;

  // Owner id for a new run: count up from the left id, skipping 0 and the
  // right id. Two steps always settle it.
  function automatic logic [7:0] pick_id(input logic [7:0] left, input logic [7:0] right);
    logic [7:0] c;
    c = left + 8'd1;
    for (int i = 0; i < 2; i++) begin
      if (c == right || c == 8'd0) begin
        c = c + 8'd1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/next_fit_block_map_allocator.sv =====
// ----------------------------------------------------------------------------
// next_fit_block_map_allocator
// One request in work at a time; while it is in work, the map port moves one
//   block per cycle.
// Reset: synchronous, active low; a clearing pass zeroes the whole map before
//   the first request is taken.
// The result sits in an output register; the next request is taken while it
//   waits.
// ----------------------------------------------------------------------------
module next_fit_block_map_allocator #(
  parameter int NUM_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [14:0] request_bytes, [24:15] free_index
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [9:0] block_index, [20:10] block_count,
                                  // [31:21] free_blocks
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data // region_blocks
);

  import nfba_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);

  logic [REG_W-1:0] region_blocks_r;
  logic             res_valid, res_ready;
  res_t             res;
  res_t             out_res_r;
  logic             out_valid_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_rdata;

  // Region size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_blocks_r <= REGION_RESET;
    end else if (cfg_wr_en) begin
      region_blocks_r <= cfg_wr_data;
    end
  end

  nfba_engine #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .req_type      (in_tuser),
    .request_bytes (in_tdata[14:0]),
    .free_index    (in_tdata[24:15]),
    .region_blocks (region_blocks_r),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  nfba_map_mem #(
    .DEPTH (NUM_BLOCKS)
  ) u_map (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  // Output register: loads when empty or when its result is being taken
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {out_res_r.free_blocks, out_res_r.block_count, out_res_r.block_index};

  // A taken request keeps the engine busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("engine took a second request back to back");

  // Refused or ignored requests report neither index nor count
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_DONE) |-> (out_tdata[20:0] == 21'd0))
    else $error("refused request carries an index or count");

  // A new result only follows a cycle in which the engine was busy
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without work in progress");

endmodule

// ===== rtl/nfba_map_mem.sv =====
// ----------------------------------------------------------------------------
// nfba_map_mem
// Block map storage: one byte per block, one write and one registered read
// port.
// ----------------------------------------------------------------------------
module nfba_map_mem #(
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata_r
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

// ===== rtl/nfba_engine.sv =====
// ----------------------------------------------------------------------------
// nfba_engine
// Request sequencer: init sweep, next-fit scan with run stamping, and run
// release; the scan and the release work by read-modify-write on the block map.
// ----------------------------------------------------------------------------
module nfba_engine #(
  parameter  int NUM_BLOCKS  = 1024,
  parameter  int BLOCK_BYTES = 16,
  localparam int AW          = $clog2(NUM_BLOCKS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request side
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   req_type,
  input  logic [nfba_pkg::BYTES_W-1:0] request_bytes,
  input  logic [nfba_pkg::IDX_W-1:0]   free_index,
  input  logic [nfba_pkg::REG_W-1:0]   region_blocks,
  // result side
  output logic                         res_valid,
  input  logic                         res_ready,
  output nfba_pkg::res_t               res,
  // block map port
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [7:0]                   mem_wdata,
  output logic [AW-1:0]                mem_raddr,
  input  logic [7:0]                   mem_rdata
);

  import nfba_pkg::*;

  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int WW = ((CW > BYTES_W) ? CW : BYTES_W) + 1;
  localparam int NW = BYTES_W;
  // ceil division by BLOCK_BYTES through a reciprocal multiply
  localparam int    QW    = 17;
  localparam int    SH    = QW + $clog2(BLOCK_BYTES);
  localparam int    MW    = QW + 2;
  localparam int    PW    = QW + MW;
  localparam longint RECIP = ((longint'(1) <<< SH) + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam int    RESET_REGION = (NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024;

  function automatic logic [QW-1:0] div_blocks(input logic [QW-1:0] x);
    logic [PW-1:0] p;
    p = PW'(x) * PW'(RECIP);
    return QW'(p >> SH);
  endfunction

  // Control state
  eng_state_t      state_r, state_nxt;
  logic            init_r, init_nxt;
  logic [AW-1:0]   sw_r, sw_nxt;
  logic [CW-1:0]   hdr_r, hdr_nxt;
  logic [CW-1:0]   used_r, used_nxt;
  logic [AW-1:0]   nfp_r, nfp_nxt;
  logic [CW-1:0]   region_r, region_nxt;

  // Request payload and work registers
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [IDX_W-1:0]   fidx_r, fidx_nxt;
  logic [NW-1:0]      need_r, need_nxt;
  logic [AW-1:0]      x_r, x_nxt;
  logic [AW-1:0]      start_r, start_nxt;
  logic [NW-1:0]      y_r, y_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;
  logic               in_run_r, in_run_nxt;
  logic               first_r, first_nxt;
  logic [7:0]         left_r, left_nxt;
  logic [7:0]         id_r, id_nxt;
  logic [CW-1:0]      fcnt_r, fcnt_nxt;
  status_t            res_st_r, res_st_nxt;
  logic [AW-1:0]      res_idx_r, res_idx_nxt;
  logic [CW-1:0]      res_cnt_r, res_cnt_nxt;

  // Shared position logic
  logic [AW-1:0] x_inc, x0;
  logic          x_last;
  logic          rd_zero;
  logic [NW-1:0] y_new, run_len;
  logic          scan_hit, end_run, end_at_last, run_fail;
  logic          in_run_after, scan_miss;
  logic [CW-1:0] rem_after;
  logic          f_match, f_end;
  logic [CW-1:0] f_cnt;
  logic [CW-1:0] region_clamp;
  logic          no_room;
  logic [7:0]    right_v;
  logic [CW-1:0] free_cnt;

  assign x_last  = (WW'(x_r) + WW'(1) == WW'(region_r));
  assign x_inc   = (WW'(x_r) + WW'(1) >= WW'(region_r)) ? '0 : x_r + AW'(1);
  assign x0      = (WW'(nfp_r) + WW'(1) >= WW'(region_r)) ? '0 : nfp_r + AW'(1);
  assign rd_zero = (mem_rdata == 8'd0);

  // Scan step: one block visited per cycle
  assign y_new        = in_run_r ? y_r + NW'(1) : NW'(1);
  assign scan_hit     = rd_zero && (y_new == need_r);
  assign end_run      = in_run_r && !rd_zero;
  assign end_at_last  = rd_zero && !scan_hit && x_last;
  assign run_len      = rd_zero ? y_new : y_r;
  assign run_fail     = (end_run || end_at_last) && (WW'(run_len) >= WW'(rem_r));
  assign in_run_after = rd_zero && !x_last;

  always_comb begin
    if (end_at_last) begin
      rem_after = rem_r - CW'(y_new);
    end else if (end_run) begin
      rem_after = rem_r - CW'(y_r) - CW'(1);
    end else if (!rd_zero) begin
      rem_after = rem_r - CW'(1);
    end else begin
      rem_after = rem_r;
    end
  end

  assign scan_miss = !scan_hit && (run_fail || (!in_run_after && rem_after == '0));

  // Release walk
  assign f_match = first_r ? !rd_zero : (mem_rdata == id_r);
  assign f_end   = !f_match || x_last;
  assign f_cnt   = f_match ? fcnt_r + CW'(1) : fcnt_r;

  // Region size register saturates to the map depth
  assign region_clamp = (WW'(region_blocks) > WW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                                                               : CW'(region_blocks);

  assign no_room = (WW'(need_r) > WW'(region_r)) ||
                   (WW'(used_r) + WW'(need_r) > WW'(region_r));

  assign right_v = (WW'(start_r) + WW'(need_r) < WW'(region_r)) ? mem_rdata : 8'd0;

  assign free_cnt = (used_r >= region_r) ? '0 : region_r - used_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP: begin
        if (sw_r == AW'(NUM_BLOCKS - 1)) begin
          state_nxt = init_r ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (req_type)
            REQ_ALLOC: state_nxt = S_APREP;
            REQ_FREE:  state_nxt = S_FCHK;
            REQ_INIT:  state_nxt = S_IPREP;
            default:   state_nxt = S_FINISH;
          endcase
        end
      end
      S_IPREP: state_nxt = S_IDIV;
      S_IDIV:  state_nxt = S_SWEEP;
      S_APREP: state_nxt = S_ACHK;
      S_ACHK: begin
        state_nxt = (need_r == '0 || no_room) ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_nxt = S_LEFT;
        end else if (scan_miss) begin
          state_nxt = S_FINISH;
        end
      end
      S_LEFT:  state_nxt = S_RIGHT;
      S_RIGHT: state_nxt = S_PICK;
      S_PICK:  state_nxt = S_FILL;
      S_FILL: begin
        if (y_r == NW'(1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_FCHK: begin
        state_nxt = (WW'(fidx_r) >= WW'(region_r)) ? S_FINISH : S_FWALK;
      end
      S_FWALK: begin
        if (f_end) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = x_r;
    mem_wdata   = 8'd0;
    mem_raddr   = x_r;
    init_nxt    = init_r;
    sw_nxt      = sw_r;
    hdr_nxt     = hdr_r;
    used_nxt    = used_r;
    nfp_nxt     = nfp_r;
    region_nxt  = region_r;
    bytes_nxt   = bytes_r;
    fidx_nxt    = fidx_r;
    need_nxt    = need_r;
    x_nxt       = x_r;
    start_nxt   = start_r;
    y_nxt       = y_r;
    rem_nxt     = rem_r;
    in_run_nxt  = in_run_r;
    first_nxt   = first_r;
    left_nxt    = left_r;
    id_nxt      = id_r;
    fcnt_nxt    = fcnt_r;
    res_st_nxt  = res_st_r;
    res_idx_nxt = res_idx_r;
    res_cnt_nxt = res_cnt_r;

    unique case (state_r)
      // whole-map write: header ids below hdr_r, zero from hdr_r up
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sw_r;
        mem_wdata = (CW'(sw_r) < hdr_r) ? HEADER_ID : 8'd0;
        sw_nxt    = sw_r + AW'(1);
        if (sw_r == AW'(NUM_BLOCKS - 1) && init_r) begin
          init_nxt    = 1'b0;
          used_nxt    = hdr_r;
          nfp_nxt     = (hdr_r == '0) ? '0 : AW'(hdr_r - CW'(1));
          res_st_nxt  = ST_DONE;
          res_idx_nxt = '0;
          res_cnt_nxt = hdr_r;
        end
      end
      S_IDLE: begin
        bytes_nxt   = request_bytes;
        fidx_nxt    = free_index;
        res_st_nxt  = ST_IGNORED;
        res_idx_nxt = '0;
        res_cnt_nxt = '0;
      end
      S_IPREP: begin
        region_nxt = region_clamp;
      end
      S_IDIV: begin
        hdr_nxt  = CW'(div_blocks(QW'(region_r) + QW'(BLOCK_BYTES - 1)));
        init_nxt = 1'b1;
        sw_nxt   = '0;
      end
      S_APREP: begin
        need_nxt = NW'(div_blocks(QW'(bytes_r) + QW'(BLOCK_BYTES - 1)));
      end
      // size checks, then start the scan just past the last run placed
      S_ACHK: begin
        if (need_r != '0 && no_room) begin
          res_st_nxt = ST_NOROOM;
        end
        mem_raddr  = x0;
        x_nxt      = x0;
        rem_nxt    = region_r;
        in_run_nxt = 1'b0;
        y_nxt      = '0;
      end
      S_SCAN: begin
        mem_raddr  = x_inc;
        x_nxt      = x_inc;
        start_nxt  = (rd_zero && !in_run_r) ? x_r : start_r;
        y_nxt      = rd_zero ? y_new : '0;
        in_run_nxt = in_run_after;
        rem_nxt    = rem_after;
        if (scan_miss) begin
          res_st_nxt = ST_NOROOM;
        end
      end
      // neighbor ids of the run found
      S_LEFT: begin
        mem_raddr = start_r - AW'(1);
      end
      S_RIGHT: begin
        mem_raddr = AW'(WW'(start_r) + WW'(need_r));
        left_nxt  = (start_r == '0) ? 8'd0 : mem_rdata;
      end
      S_PICK: begin
        id_nxt = pick_id(left_r, right_v);
        y_nxt  = need_r;
        x_nxt  = start_r;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = x_r;
        mem_wdata = id_r;
        x_nxt     = x_r + AW'(1);
        y_nxt     = y_r - NW'(1);
        if (y_r == NW'(1)) begin
          nfp_nxt     = AW'(WW'(start_r) + WW'(need_r) - WW'(1));
          used_nxt    = CW'(WW'(used_r) + WW'(need_r));
          res_st_nxt  = ST_DONE;
          res_idx_nxt = start_r;
          res_cnt_nxt = CW'(need_r);
        end
      end
      S_FCHK: begin
        mem_raddr = AW'(fidx_r);
        x_nxt     = AW'(fidx_r);
        first_nxt = 1'b1;
        fcnt_nxt  = '0;
      end
      // clear blocks while their id matches the first one
      S_FWALK: begin
        mem_raddr = x_inc;
        first_nxt = 1'b0;
        if (first_r) begin
          id_nxt = mem_rdata;
        end
        if (f_match) begin
          mem_we   = 1'b1;
          mem_waddr = x_r;
          fcnt_nxt = fcnt_r + CW'(1);
          x_nxt    = x_inc;
        end
        if (f_end && !(first_r && !f_match)) begin
          used_nxt    = (used_r >= f_cnt) ? used_r - f_cnt : '0;
          res_st_nxt  = ST_DONE;
          res_idx_nxt = AW'(fidx_r);
          res_cnt_nxt = f_cnt;
        end
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_SWEEP;
      init_r   <= 1'b0;
      sw_r     <= '0;
      hdr_r    <= '0;
      used_r   <= '0;
      nfp_r    <= '0;
      region_r <= CW'(RESET_REGION);
    end else begin
      state_r  <= state_nxt;
      init_r   <= init_nxt;
      sw_r     <= sw_nxt;
      hdr_r    <= hdr_nxt;
      used_r   <= used_nxt;
      nfp_r    <= nfp_nxt;
      region_r <= region_nxt;
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    bytes_r   <= bytes_nxt;
    fidx_r    <= fidx_nxt;
    need_r    <= need_nxt;
    x_r       <= x_nxt;
    start_r   <= start_nxt;
    y_r       <= y_nxt;
    rem_r     <= rem_nxt;
    in_run_r  <= in_run_nxt;
    first_r   <= first_nxt;
    left_r    <= left_nxt;
    id_r      <= id_nxt;
    fcnt_r    <= fcnt_nxt;
    res_st_r  <= res_st_nxt;
    res_idx_r <= res_idx_nxt;
    res_cnt_r <= res_cnt_nxt;
  end

  assign in_ready              = (state_r == S_IDLE);
  assign res_valid             = (state_r == S_FINISH);
  assign res.status            = res_st_r;
  assign res.block_index       = IDX_W'(res_idx_r);
  assign res.block_count       = CNT_W'(res_cnt_r);
  assign res.free_blocks       = CNT_W'(free_cnt);

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, free and init requests into the next-fit block map
// allocator. A model of the block map, kept in step with every accepted
// request, predicts each reply, and the replies are compared field by field.
// Region sizes change between phases while the block is idle; both streams
// stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import nfba_pkg::*;

  localparam int NBLK         = 1024;
  localparam int BLK_BYTES    = 16;
  localparam int STALL_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 2100;
  localparam int RANDOM_ITEMS = 560;
  localparam int NUM_PHASES   = 7;

  // Map model, expected replies and the check against the block's replies
  class alloc_tracker;
    logic [7:0] bmap [NBLK];
    int         used_blocks;
    int         last_pos;
    int         region_reg;
    int         region_len;
    res_t       replies_due [$];
    int         errors;

    function new();
      foreach (bmap[i]) bmap[i] = 8'd0;
      used_blocks = 0;
      last_pos    = 0;
      region_reg  = int'(REGION_RESET);
      region_len  = (region_reg > NBLK) ? NBLK : region_reg;
      errors      = 0;
    endfunction

    function int free_count();
      return (used_blocks >= region_len) ? 0 : region_len - used_blocks;
    endfunction

    function res_t make_reply(status_t st, int at, int cnt);
      res_t r;
      r.status      = st;
      r.block_index = IDX_W'(at);
      r.block_count = CNT_W'(cnt);
      r.free_blocks = CNT_W'(free_count());
      return r;
    endfunction

    // Clear the map and reserve the header run
    function res_t init_map();
      int n;
      int hdr;
      n   = (region_reg > NBLK) ? NBLK : region_reg;
      hdr = (n + BLK_BYTES - 1) / BLK_BYTES;
      foreach (bmap[i]) bmap[i] = 8'd0;
      for (int i = 0; i < hdr && i < n; i++) bmap[i] = HEADER_ID;
      region_len  = n;
      used_blocks = hdr;
      last_pos    = (hdr > 0) ? hdr - 1 : 0;
      return make_reply(ST_DONE, 0, hdr);
    endfunction

    // Next-fit scan for a free run that does not wrap
    function res_t alloc_run(int nbytes);
      int         n;
      int         need;
      int         x;
      int         remaining;
      int         y;
      logic [7:0] left;
      logic [7:0] right;
      logic [7:0] id;
      n    = region_len;
      need = (nbytes + BLK_BYTES - 1) / BLK_BYTES;
      if (need == 0) return make_reply(ST_IGNORED, 0, 0);
      if (need > n || used_blocks + need > n) return make_reply(ST_NOROOM, 0, 0);
      x         = (last_pos + 1 >= n) ? 0 : last_pos + 1;
      remaining = n;
      while (remaining > 0) begin
        if (x >= n) x = 0;
        if (bmap[x] == 8'd0) begin
          y = 0;
          while (y < need && x + y < n && bmap[x + y] == 8'd0) y++;
          if (y == need) begin
            left  = (x > 0) ? bmap[x - 1] : 8'd0;
            right = (x + need < n) ? bmap[x + need] : 8'd0;
            id    = left + 8'd1;
            while (id == right || id == 8'd0) id = id + 8'd1;
            for (int z = 0; z < need; z++) bmap[x + z] = id;
            last_pos     = x + need - 1;
            used_blocks += need;
            return make_reply(ST_DONE, x, need);
          end
          if (y >= remaining) break;
          remaining -= y;
          x         += y;
        end else begin
          remaining--;
          x++;
        end
      end
      return make_reply(ST_NOROOM, 0, 0);
    endfunction

    // Clear from the given index to the end of its run of equal ids
    function res_t free_run(int at);
      int         n;
      int         x;
      int         cnt;
      logic [7:0] id;
      n = region_len;
      if (at >= n || bmap[at] == 8'd0) return make_reply(ST_IGNORED, 0, 0);
      id = bmap[at];
      x  = at;
      while (x < n && bmap[x] == id) begin
        bmap[x] = 8'd0;
        x++;
      end
      cnt         = x - at;
      used_blocks = (used_blocks >= cnt) ? used_blocks - cnt : 0;
      return make_reply(ST_DONE, at, cnt);
    endfunction

    // First block of an owned run at or after the given index, -1 if none
    function int find_run_start(int from);
      int i;
      for (int k = 0; k < region_len; k++) begin
        i = (from + k) % region_len;
        if (bmap[i] != 8'd0 && (i == 0 || bmap[i - 1] != bmap[i])) return i;
      end
      return -1;
    endfunction

    // Request transfer accepted: update the model, queue the reply
    function void take_request(logic [1:0] kind, logic [14:0] nbytes, logic [9:0] at);
      res_t r;
      case (kind)
        REQ_ALLOC: r = alloc_run(int'(nbytes));
        REQ_FREE:  r = free_run(int'(at));
        REQ_INIT:  r = init_map();
        default:   r = make_reply(ST_IGNORED, 0, 0);
      endcase
      replies_due.push_back(r);
    endfunction

    // Reply transfer accepted: compare with the oldest expected reply
    function void match_reply(logic [1:0] st, logic [31:0] data);
      res_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: reply with none expected: status %0d, data %h", $time, st, data);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (st != want.status) begin
        $display("%0t: status expected %0d, actual %0d", $time, want.status, st);
        errors++;
      end
      if (data[9:0] != want.block_index) begin
        $display("%0t: block_index expected %0d, actual %0d", $time,
                 want.block_index, data[9:0]);
        errors++;
      end
      if (data[20:10] != want.block_count) begin
        $display("%0t: block_count expected %0d, actual %0d", $time,
                 want.block_count, data[20:10]);
        errors++;
      end
      if (data[31:21] != want.free_blocks) begin
        $display("%0t: free_blocks expected %0d, actual %0d", $time,
                 want.free_blocks, data[31:21]);
        errors++;
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = 32'd0;
  logic [1:0]  in_tuser    = 2'd0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en   = 1'b0;
  logic [10:0] cfg_wr_data = 11'd0;

  bit           steady = 1'b0;
  int           stall_cycles;
  alloc_tracker tracker;

  always #5 clk = ~clk;

  next_fit_block_map_allocator #(
    .NUM_BLOCKS  (NBLK),
    .BLOCK_BYTES (BLK_BYTES)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // [14:0] request_bytes, [24:15] free_index
    .in_tuser    (in_tuser),    // [1:0] req_type
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // [9:0] block_index, [20:10] block_count,
                                // [31:21] free_blocks
    .out_tuser   (out_tuser),   // [1:0] status
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)  // region_blocks
  );

  // Reply side: check each transfer, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.match_reply(out_tuser, out_tdata);
    out_tready <= steady || ($urandom_range(99) >= 11);
  end

  // Watchdog on cycles without any transfer
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // One request transfer, with a random gap ahead of it
  task automatic send_req(input logic [1:0] kind, input int nbytes, input int at);
    while (!steady && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, IDX_W'(at), BYTES_W'(nbytes)};
    do @(posedge clk); while (!in_tready);
    tracker.take_request(kind, BYTES_W'(nbytes), IDX_W'(at));
  endtask

  // Let every expected reply arrive
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tracker.replies_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_region(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= REG_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.region_reg = value & 2047;
  endtask

  // Mostly well-formed traffic: small allocations and frees of live runs
  task automatic random_req();
    int n;
    int pick;
    int sz;
    int need;
    int at;
    n    = tracker.region_len;
    pick = $urandom_range(99);
    if (pick < 52) begin
      sz = $urandom_range(99);
      if (sz < 4) begin
        send_req(REQ_ALLOC, 0, $urandom_range(1023));
      end else if (sz < 9) begin
        send_req(REQ_ALLOC, $urandom_range(32767), $urandom_range(1023));
      end else begin
        if (sz < 20 && n > 0) need = $urandom_range(1, n);
        else need = $urandom_range(1, (n / 8 > 1) ? n / 8 : 2);
        send_req(REQ_ALLOC, (need - 1) * BLK_BYTES + $urandom_range(1, BLK_BYTES),
                 $urandom_range(1023));
      end
    end else if (pick < 86) begin
      at = (n > 0) ? tracker.find_run_start($urandom_range(1023)) : -1;
      send_req(REQ_FREE, $urandom_range(32767), (at < 0) ? $urandom_range(1023) : at);
    end else if (pick < 89) begin
      // free from inside a run
      at = (n > 0) ? tracker.find_run_start($urandom_range(1023)) : -1;
      if (at >= 0) at = at + $urandom_range(1, 3);
      send_req(REQ_FREE, $urandom_range(32767), (at < 0 || at > 1023) ? 0 : at);
    end else if (pick < 94) begin
      send_req(REQ_FREE, $urandom_range(32767), $urandom_range(1023));
    end else if (pick < 97) begin
      send_req(REQ_INIT, $urandom_range(32767), $urandom_range(1023));
    end else begin
      send_req(2'd3, $urandom_range(32767), $urandom_range(1023));
    end
  endtask

  initial begin
    int region_list [NUM_PHASES];
    int region;
    region_list = '{1024, 16, 2047, -1, 0, 40, -2};
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Before any init: whole map free, nothing reserved
    send_req(REQ_ALLOC, 1, 0);
    send_req(REQ_FREE, 0, 1);
    send_req(REQ_ALLOC, 0, 0);
    send_req(2'd3, 0, 0);
    send_req(REQ_FREE, 0, 500);

    // Default region: totals, rounding, partial and header frees
    send_req(REQ_INIT, 0, 0);
    send_req(REQ_ALLOC, 16384, 0);
    send_req(REQ_ALLOC, 32767, 1023);
    send_req(REQ_ALLOC, 15, 0);
    send_req(REQ_ALLOC, 17, 0);
    send_req(REQ_ALLOC, 16, 0);
    send_req(REQ_FREE, 0, 66);
    send_req(REQ_FREE, 0, 10);
    send_req(REQ_FREE, 0, 1023);

    // Region of 16 blocks: run up to the last block, then a run at block 0
    wait_idle();
    write_region(16);
    send_req(REQ_INIT, 0, 0);
    send_req(REQ_ALLOC, 240, 0);
    send_req(REQ_ALLOC, 16, 0);
    send_req(REQ_FREE, 0, 0);
    send_req(REQ_ALLOC, 1, 0);
    send_req(REQ_FREE, 0, 16);

    // Empty region
    wait_idle();
    write_region(0);
    send_req(REQ_INIT, 0, 0);
    send_req(REQ_ALLOC, 1, 0);

    // Register above the block count saturates; fill the region exactly
    wait_idle();
    write_region(2047);
    send_req(REQ_INIT, 0, 0);
    send_req(REQ_ALLOC, 15360, 0);
    send_req(REQ_FREE, 0, 64);

    // Random phases, one region setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (region_list[p] == -1) region = $urandom_range(17, 1023);
      else if (region_list[p] == -2) region = $urandom_range(2047);
      else region = region_list[p];
      steady = (p == 3);
      write_region(region);
      send_req(REQ_INIT, $urandom_range(32767), $urandom_range(1023));
      for (int k = 0; k < RANDOM_ITEMS / NUM_PHASES; k++) random_req();
    end
    steady = 1'b0;

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.replies_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
